// ===== hdl/rgbenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbenc_pkg
// Types and constants shared by the RGB LED strip line encoder modules.
// ----------------------------------------------------------------------------
package rgbenc_pkg;

    localparam int BYTES_PER_PIXEL = 3;

    localparam int TICK_W     = 12;
    localparam int IDLE_W     = 21;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;
    localparam logic [1:0] CMD_SHOW = 2'd3;

    // byte of a pixel being written
    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP   = 3'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic sending;
        logic accepted;
    } out_item_t;

    typedef struct packed {
        logic [8:0]        pixel_count;
        logic [8:0]        color_order;
        logic [7:0]        brightness;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] bit_period_ticks;
        logic [19:0]       reset_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic wr_step;
        logic fetch;
        logic load;
        logic load_show;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic show_ready;
        logic need_fetch;
        logic write_go;
        logic write_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ===== hdl/rgb_led_strip_line_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_strip_line_encoder
// One-wire line encoder for an addressable RGB pixel strip: a byte store of
// three colour bytes per pixel, sent scaled by brightness as timed bit slots.
// ----------------------------------------------------------------------------
// result: a plain tick's result is registered in the cycle after the transaction;
//   a show's result passes a store read, then the scale, before it is registered
// rate: one tick per cycle while the receiver takes each result; a tick that moves
//   to the next byte adds the store read; set pixel sweeps three bytes, fill 3*pixels
// reset: after aresetn the store is cleared one byte a cycle, during which no
//   transaction is taken; config writes still land
module rgb_led_strip_line_encoder #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rgbenc_pkg::in_item_t                  s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rgbenc_pkg::out_item_t                 m_data,
    input  logic                                  cfg_wr_en,
    input  logic [rgbenc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgbenc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int STORE_BYTES = MAX_PIXELS * rgbenc_pkg::BYTES_PER_PIXEL;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    rgbenc_pkg::cfg_t       cfg_reg, cfg_next;
    rgbenc_pkg::ctrl_cmd_t  cmd;
    rgbenc_pkg::ctrl_stat_t stat;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rgbenc_pkg::REG_PIXEL_COUNT: cfg_next.pixel_count      = cfg_wdata[8:0];
                rgbenc_pkg::REG_COLOR_ORDER: cfg_next.color_order      = cfg_wdata[8:0];
                rgbenc_pkg::REG_BRIGHTNESS:  cfg_next.brightness       = cfg_wdata[7:0];
                rgbenc_pkg::REG_ZERO_HIGH:   cfg_next.zero_high_ticks  = cfg_wdata[11:0];
                rgbenc_pkg::REG_ONE_HIGH:    cfg_next.one_high_ticks   = cfg_wdata[11:0];
                rgbenc_pkg::REG_BIT_PERIOD:  cfg_next.bit_period_ticks = cfg_wdata[11:0];
                rgbenc_pkg::REG_RESET_GAP:   cfg_next.reset_gap_ticks  = cfg_wdata[19:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_count      <= 9'd1;
            cfg_reg.color_order      <= 9'd80;
            cfg_reg.brightness       <= 8'd255;
            cfg_reg.zero_high_ticks  <= 12'd32;
            cfg_reg.one_high_ticks   <= 12'd64;
            cfg_reg.bit_period_ticks <= 12'd100;
            cfg_reg.reset_gap_ticks  <= 20'd4000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rgbenc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rgbenc_dpath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rgbenc_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== hdl/rgbenc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbenc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbenc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rgbenc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbenc_ctrl
// Controller: clearing pass, item acceptance, byte fetch and store write sweep.
// ----------------------------------------------------------------------------
module rgbenc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  rgbenc_pkg::ctrl_stat_t stat,
    output rgbenc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SHOW_FETCH,
        ST_SHOW_LOAD,
        ST_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept  = s_ready && s_valid;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (stat.show_ready) begin
                        state_next = ST_SHOW_FETCH;
                    end else if (stat.need_fetch) begin
                        state_next = ST_FETCH;
                    end else if (stat.write_go) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_FETCH:      state_next = ST_LOAD;
            ST_LOAD:       state_next = ST_IDLE;
            ST_SHOW_FETCH: state_next = ST_SHOW_LOAD;
            ST_SHOW_LOAD:  state_next = ST_IDLE;
            ST_WRITE: begin
                if (stat.write_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd.accept    = accept;
        cmd.clr_step  = (state_reg == ST_CLEAR);
        cmd.wr_step   = (state_reg == ST_WRITE);
        cmd.fetch     = (state_reg == ST_FETCH) || (state_reg == ST_SHOW_FETCH);
        cmd.load      = (state_reg == ST_LOAD) || (state_reg == ST_SHOW_LOAD);
        cmd.load_show = (state_reg == ST_SHOW_LOAD);
    end

endmodule

// ===== hdl/rgbenc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbenc_dpath
// Datapath: bit slot timing, frame pointers, idle counter, store writes and
// the registered result.
// ----------------------------------------------------------------------------
module rgbenc_dpath #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rgbenc_pkg::cfg_t       cfg,
    input  rgbenc_pkg::in_item_t   s_data,
    input  rgbenc_pkg::ctrl_cmd_t  cmd,
    output rgbenc_pkg::ctrl_stat_t stat,
    output logic                   m_valid,
    input  logic                   m_ready,
    output rgbenc_pkg::out_item_t  m_data,
    output logic                   mem_wr_en,
    output logic [$clog2(MAX_PIXELS*rgbenc_pkg::BYTES_PER_PIXEL)-1:0] mem_wr_addr,
    output logic [7:0]             mem_wr_data,
    output logic                   mem_rd_en,
    output logic [$clog2(MAX_PIXELS*rgbenc_pkg::BYTES_PER_PIXEL)-1:0] mem_rd_addr,
    input  logic [7:0]             mem_rd_data
);

    localparam int STORE_BYTES = MAX_PIXELS * rgbenc_pkg::BYTES_PER_PIXEL;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int BPTR_W      = $clog2(STORE_BYTES + 1);
    localparam int NPIX_W      = $clog2(MAX_PIXELS + 1);
    localparam int PIX_W       = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CHK_W       = $clog2(STORE_BYTES + 8);
    localparam int CNT_W       = (NPIX_W > 9) ? NPIX_W : 9;
    localparam int TW          = rgbenc_pkg::TICK_W;
    localparam int IW          = rgbenc_pkg::IDLE_W;

    function automatic logic [TW-1:0] pick(input logic [7:0] s, input logic [2:0] pos,
                                           input logic [TW-1:0] one_t,
                                           input logic [TW-1:0] zero_t);
        return s[3'd7 - pos] ? one_t : zero_t;
    endfunction

    // frame and idle state
    logic              frame_reg, frame_next;
    logic [BPTR_W-1:0] ptr_reg, ptr_next;
    logic [2:0]        bitpos_reg, bitpos_next;
    logic [TW-1:0]     tick_reg, tick_next;
    logic [TW-1:0]     high_reg, high_next;
    logic [IW-1:0]     idle_reg, idle_next;
    logic [7:0]        byte_reg, byte_next;

    // clearing pass and write sweep
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [PIX_W-1:0]  wr_pix_reg, wr_pix_next;
    logic [PIX_W-1:0]  wr_end_reg, wr_end_next;
    logic [1:0]        wr_col_reg, wr_col_next;
    logic [7:0]        wr_red_reg, wr_green_reg, wr_blue_reg;

    // result register
    logic                  m_valid_reg, m_valid_next;
    rgbenc_pkg::out_item_t m_data_reg, res;
    logic                  res_load;

    logic [NPIX_W-1:0] n_pix;
    logic              n_zero;
    logic [CHK_W-1:0]  limit;
    logic              idx_ok, gap_ok;
    logic              is_tick, is_set, is_fill, is_show;
    logic              show_ready, write_go, acc_now;

    logic [7:0]        mul_a, scaled;
    logic [15:0]       product;
    logic [TW-1:0]     t_high, tick_inc, period;
    logic              line, slot_end, frame_done, tick_en, need_fetch;
    logic [2:0]        bitpos_inc;
    logic [BPTR_W-1:0] ptr_inc;

    logic [2:0]        wr_off;
    logic [7:0]        wr_byte;
    logic [CHK_W-1:0]  wr_addr_full;
    logic              wr_in_range;

    // pixel count saturates at the store size
    assign n_pix  = (CNT_W'(cfg.pixel_count) > CNT_W'(MAX_PIXELS)) ?
                    NPIX_W'(MAX_PIXELS) : NPIX_W'(cfg.pixel_count);
    assign n_zero = (n_pix == '0);
    assign limit  = CHK_W'({n_pix, 1'b0}) + CHK_W'(n_pix);
    assign idx_ok = CNT_W'(s_data.pixel_index) < CNT_W'(n_pix);
    assign gap_ok = idle_reg > IW'(cfg.reset_gap_ticks);

    assign is_tick = (s_data.cmd == rgbenc_pkg::CMD_TICK);
    assign is_set  = (s_data.cmd == rgbenc_pkg::CMD_SET);
    assign is_fill = (s_data.cmd == rgbenc_pkg::CMD_FILL);
    assign is_show = (s_data.cmd == rgbenc_pkg::CMD_SHOW);

    assign show_ready = !frame_reg && is_show && gap_ok && !n_zero;
    assign write_go   = !frame_reg && ((is_set && idx_ok) || (is_fill && !n_zero));
    assign acc_now    = frame_reg ? is_tick :
                        (is_set ? idx_ok : (is_show ? gap_ok : 1'b1));

    // brightness scaling, operand comes from the store on a load cycle
    assign mul_a   = cmd.load ? mem_rd_data : byte_reg;
    assign product = 16'(mul_a) * 16'(cfg.brightness);
    assign scaled  = product[15:8];

    // slot timing
    assign t_high     = cmd.load_show ?
                        pick(scaled, 3'd0, cfg.one_high_ticks, cfg.zero_high_ticks) : high_reg;
    assign line       = tick_reg < t_high;
    assign tick_inc   = tick_reg + TW'(1);
    assign period     = (cfg.bit_period_ticks == '0) ? TW'(1) : cfg.bit_period_ticks;
    assign slot_end   = (tick_inc >= period) || (tick_inc == '0);
    assign bitpos_inc = bitpos_reg + 3'd1;
    assign ptr_inc    = (bitpos_inc == '0) ? ptr_reg + BPTR_W'(1) : ptr_reg;
    assign frame_done = CHK_W'(ptr_inc) >= limit;
    assign tick_en    = (cmd.accept && frame_reg) || cmd.load_show;
    assign need_fetch = frame_reg && slot_end && !frame_done && (bitpos_inc == '0);

    // store write sweep
    always_comb begin
        case (wr_col_reg)
            rgbenc_pkg::COL_RED: begin
                wr_off  = cfg.color_order[8:6];
                wr_byte = wr_red_reg;
            end
            rgbenc_pkg::COL_GREEN: begin
                wr_off  = cfg.color_order[5:3];
                wr_byte = wr_green_reg;
            end
            default: begin
                wr_off  = cfg.color_order[2:0];
                wr_byte = wr_blue_reg;
            end
        endcase
    end

    assign wr_addr_full = CHK_W'({wr_pix_reg, 1'b0}) + CHK_W'(wr_pix_reg) + CHK_W'(wr_off);
    assign wr_in_range  = wr_addr_full < limit;

    assign mem_wr_en   = cmd.clr_step || (cmd.wr_step && wr_in_range);
    assign mem_wr_addr = cmd.clr_step ? clr_reg : wr_addr_full[ADDR_W-1:0];
    assign mem_wr_data = cmd.clr_step ? 8'd0 : wr_byte;
    assign mem_rd_en   = cmd.fetch;
    assign mem_rd_addr = ptr_reg[ADDR_W-1:0];

    // result of the transaction
    always_comb begin
        if (cmd.load_show) begin
            res.line_level = line;
            res.sending    = 1'b1;
            res.accepted   = 1'b1;
        end else begin
            res.line_level = frame_reg && line;
            res.sending    = frame_reg;
            res.accepted   = acc_now;
        end
    end

    assign res_load = (cmd.accept && !show_ready) || cmd.load_show;

    always_comb begin
        frame_next   = frame_reg;
        ptr_next     = ptr_reg;
        bitpos_next  = bitpos_reg;
        tick_next    = tick_reg;
        high_next    = high_reg;
        idle_next    = idle_reg;
        byte_next    = byte_reg;
        clr_next     = clr_reg;
        wr_pix_next  = wr_pix_reg;
        wr_end_next  = wr_end_reg;
        wr_col_next  = wr_col_reg;
        m_valid_next = res_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        if (cmd.clr_step) begin
            clr_next = clr_reg + ADDR_W'(1);
        end

        if (cmd.accept && !frame_reg) begin
            if (is_show && gap_ok) begin
                if (n_zero) begin
                    idle_next = '0;
                end
            end else if (idle_reg != rgbenc_pkg::IDLE_MAX) begin
                idle_next = idle_reg + IW'(1);
            end
        end

        if (cmd.accept && write_go) begin
            wr_pix_next = is_set ? PIX_W'(s_data.pixel_index) : '0;
            wr_end_next = is_set ? PIX_W'(s_data.pixel_index) : PIX_W'(n_pix - NPIX_W'(1));
            wr_col_next = rgbenc_pkg::COL_RED;
        end

        if (cmd.wr_step) begin
            if (wr_col_reg == rgbenc_pkg::COL_BLUE) begin
                wr_col_next = rgbenc_pkg::COL_RED;
                wr_pix_next = wr_pix_reg + PIX_W'(1);
            end else begin
                wr_col_next = wr_col_reg + 2'd1;
            end
        end

        // a new byte arrives from the store: the slot starts at bit 7
        if (cmd.load) begin
            byte_next = mem_rd_data;
            if (!cmd.load_show) begin
                high_next = pick(scaled, bitpos_reg, cfg.one_high_ticks, cfg.zero_high_ticks);
            end
        end

        if (tick_en) begin
            if (slot_end) begin
                if (frame_done) begin
                    frame_next  = 1'b0;
                    ptr_next    = '0;
                    bitpos_next = '0;
                    tick_next   = '0;
                    idle_next   = '0;
                end else begin
                    frame_next  = 1'b1;
                    ptr_next    = ptr_inc;
                    bitpos_next = bitpos_inc;
                    tick_next   = '0;
                    if (bitpos_inc != '0) begin
                        high_next = pick(scaled, bitpos_inc, cfg.one_high_ticks,
                                         cfg.zero_high_ticks);
                    end
                end
            end else begin
                frame_next = 1'b1;
                tick_next  = tick_inc;
                high_next  = t_high;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg   <= 1'b0;
            ptr_reg     <= '0;
            bitpos_reg  <= '0;
            tick_reg    <= '0;
            high_reg    <= '0;
            idle_reg    <= '0;
            clr_reg     <= '0;
            wr_pix_reg  <= '0;
            wr_end_reg  <= '0;
            wr_col_reg  <= rgbenc_pkg::COL_RED;
            m_valid_reg <= 1'b0;
        end else begin
            frame_reg   <= frame_next;
            ptr_reg     <= ptr_next;
            bitpos_reg  <= bitpos_next;
            tick_reg    <= tick_next;
            high_reg    <= high_next;
            idle_reg    <= idle_next;
            clr_reg     <= clr_next;
            wr_pix_reg  <= wr_pix_next;
            wr_end_reg  <= wr_end_next;
            wr_col_reg  <= wr_col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (cmd.accept) begin
            wr_red_reg   <= s_data.red;
            wr_green_reg <= s_data.green;
            wr_blue_reg  <= s_data.blue;
        end
        if (res_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.clear_last = (clr_reg == ADDR_W'(STORE_BYTES - 1));
        stat.show_ready = show_ready;
        stat.need_fetch = need_fetch;
        stat.write_go   = write_go;
        stat.write_last = (wr_col_reg == rgbenc_pkg::COL_BLUE) && (wr_pix_reg == wr_end_reg);
        stat.out_free   = !m_valid_reg || m_ready;
    end

endmodule

// ===== verif/tb_rgb_led_strip_line_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_line_encoder
// Self-checking bench for the one-wire RGB strip encoder. Every accepted
// item is run through an in-bench model of the pixel store and bit-slot
// timing, and each result is compared field by field in order. Directed
// phases hit the corner settings, then random phases run store writes,
// show requests and whole frames under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rgb_led_strip_line_encoder;
    import rgbenc_pkg::*;

    localparam int MAX_PIX     = 256;
    localparam int STORE_BYTES = MAX_PIX * BYTES_PER_PIXEL;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 700;

    localparam logic [8:0] RGB_ORDERS [6] = '{9'o012, 9'o021, 9'o102, 9'o120, 9'o201, 9'o210};

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_THREE_OF_FIVE, RX_SPARSE} rx_mode_e;

    // model of the store, the frame engine and the idle counter
    class led_line_scoreboard;
        bit [7:0]  pix_mem [STORE_BYTES];
        bit [8:0]  pixel_count = 9'd1;
        bit [8:0]  color_order = 9'd80;
        bit [7:0]  brightness  = 8'd255;
        bit [11:0] zero_high   = 12'd32;
        bit [11:0] one_high    = 12'd64;
        bit [11:0] bit_period  = 12'd100;
        bit [19:0] reset_gap   = 20'd4000;
        bit        frame_on;
        bit [9:0]  byte_ptr;
        bit [2:0]  bit_pos;
        bit [11:0] slot_tick;
        bit [11:0] slot_high;
        bit [20:0] idle_cnt;
        out_item_t line_expected [$];
        int        errors;
        int        checked;
        int        frames;
        int        rejects;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PIXEL_COUNT: pixel_count = val[8:0];
                REG_COLOR_ORDER: color_order = val[8:0];
                REG_BRIGHTNESS:  brightness  = val[7:0];
                REG_ZERO_HIGH:   zero_high   = val[11:0];
                REG_ONE_HIGH:    one_high    = val[11:0];
                REG_BIT_PERIOD:  bit_period  = val[11:0];
                REG_RESET_GAP:   reset_gap   = val[19:0];
                default: ;
            endcase
        endfunction

        function int active_pixels();
            return (pixel_count > MAX_PIX) ? MAX_PIX : int'(pixel_count);
        endfunction

        function void put_byte(int addr, bit [7:0] v, int limit);
            if (addr < limit && addr < STORE_BYTES)
                pix_mem[addr] = v;
        endfunction

        function void write_pixel(int idx, bit [7:0] r, bit [7:0] g, bit [7:0] b);
            int limit;
            int base;
            limit = active_pixels() * BYTES_PER_PIXEL;
            base  = idx * BYTES_PER_PIXEL;
            put_byte(base + int'(color_order[8:6]), r, limit);
            put_byte(base + int'(color_order[5:3]), g, limit);
            put_byte(base + int'(color_order[2:0]), b, limit);
        endfunction

        // high time is latched here, brightness is read at slot start
        function void load_slot();
            bit [7:0]  v;
            bit [15:0] prod;
            bit [7:0]  scaled;
            v      = (byte_ptr < STORE_BYTES) ? pix_mem[byte_ptr] : 8'd0;
            prod   = v * brightness;
            scaled = prod[15:8];
            slot_high = scaled[3'd7 - bit_pos] ? one_high : zero_high;
            slot_tick = '0;
        endfunction

        function void note_item(in_item_t it);
            int        n;
            int        i;
            int        period;
            bit        acc;
            bit        line;
            bit        busy;
            out_item_t e;
            n    = active_pixels();
            acc  = 1'b1;
            line = 1'b0;
            busy = 1'b0;
            if (!frame_on) begin
                if (it.cmd == CMD_SET) begin
                    if (int'(it.pixel_index) < n)
                        write_pixel(int'(it.pixel_index), it.red, it.green, it.blue);
                    else
                        acc = 1'b0;
                end else if (it.cmd == CMD_FILL) begin
                    for (i = 0; i < n; i++)
                        write_pixel(i, it.red, it.green, it.blue);
                end else if (it.cmd == CMD_SHOW) begin
                    if (idle_cnt > reset_gap) begin
                        if (n == 0) begin
                            idle_cnt = '0;
                        end else begin
                            frame_on = 1'b1;
                            byte_ptr = '0;
                            bit_pos  = '0;
                            load_slot();
                            frames++;
                        end
                    end else begin
                        acc = 1'b0;
                    end
                end
                if (!frame_on && !(it.cmd == CMD_SHOW && acc) && idle_cnt < IDLE_MAX)
                    idle_cnt++;
            end else if (it.cmd != CMD_TICK) begin
                acc = 1'b0;
            end

            if (frame_on) begin
                period    = (bit_period < 1) ? 1 : int'(bit_period);
                busy      = 1'b1;
                line      = slot_tick < slot_high;
                slot_tick = slot_tick + 12'd1;
                if (slot_tick >= period || slot_tick == 0) begin
                    bit_pos = bit_pos + 3'd1;
                    if (bit_pos == 0)
                        byte_ptr = byte_ptr + 10'd1;
                    if (byte_ptr >= n * BYTES_PER_PIXEL) begin
                        frame_on  = 1'b0;
                        byte_ptr  = '0;
                        bit_pos   = '0;
                        slot_tick = '0;
                        idle_cnt  = '0;
                    end else begin
                        load_slot();
                    end
                end
            end

            if (!acc)
                rejects++;
            e.line_level = line;
            e.sending    = busy;
            e.accepted   = acc;
            line_expected.push_back(e);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (line_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got %b", $time, got);
                return;
            end
            want = line_expected.pop_front();
            checked++;
            if (got.line_level !== want.line_level) begin
                errors++;
                $display("%0t: line_level mismatch: expected %b, got %b",
                         $time, want.line_level, got.line_level);
            end
            if (got.sending !== want.sending) begin
                errors++;
                $display("%0t: sending mismatch: expected %b, got %b",
                         $time, want.sending, got.sending);
            end
            if (got.accepted !== want.accepted) begin
                errors++;
                $display("%0t: accepted mismatch: expected %b, got %b",
                         $time, want.accepted, got.accepted);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    led_line_scoreboard sb = new();

    int       burst_left;
    int       items_sent;
    int       phases;
    int       quiet_cycles;
    rx_mode_e rx_mode = RX_FREE;
    int       rx_left;
    int       rx_count;

    rgb_led_strip_line_encoder #(.MAX_PIXELS(MAX_PIX)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver switches between stall patterns after runs of random length
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            RX_FREE:          m_ready <= 1'b1;
            RX_COIN:          m_ready <= ($urandom_range(0, 3) != 0);
            RX_THREE_OF_FIVE: m_ready <= (rx_count % 5) < 3;
            default:          m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, sb.line_expected.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic in_item_t rand_item();
        in_item_t it;
        it.cmd         = 2'($urandom);
        it.pixel_index = 8'($urandom);
        it.red         = 8'($urandom);
        it.green       = 8'($urandom);
        it.blue        = 8'($urandom);
        return it;
    endfunction

    task automatic push_item(input in_item_t it);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] idx,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        in_item_t it;
        it.cmd         = cmd;
        it.pixel_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        push_item(it);
    endtask

    // plain tick with junk payload, or now and then a random command
    task automatic filler(input int noise_pct);
        in_item_t it;
        it = rand_item();
        if ($urandom_range(0, 99) >= noise_pct)
            it.cmd = CMD_TICK;
        push_item(it);
    endtask

    task automatic run_out_frame(input int noise_pct);
        while (sb.frame_on)
            filler(noise_pct);
    endtask

    task automatic wait_show_ready(input int noise_pct);
        while (sb.frame_on || sb.idle_cnt <= sb.reset_gap)
            filler(noise_pct);
    endtask

    // hold the sender until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.line_expected.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_setting(input cfg_t c);
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(c.pixel_count));
        write_reg(REG_COLOR_ORDER, CFG_DATA_W'(c.color_order));
        write_reg(REG_BRIGHTNESS,  CFG_DATA_W'(c.brightness));
        write_reg(REG_ZERO_HIGH,   CFG_DATA_W'(c.zero_high_ticks));
        write_reg(REG_ONE_HIGH,    CFG_DATA_W'(c.one_high_ticks));
        write_reg(REG_BIT_PERIOD,  CFG_DATA_W'(c.bit_period_ticks));
        write_reg(REG_RESET_GAP,   CFG_DATA_W'(c.reset_gap_ticks));
        phases++;
    endtask

    task automatic random_phase();
        cfg_t     c;
        in_item_t it;
        int       r;
        int       n;
        int       shows;
        int       k;
        int       i;
        r = $urandom_range(0, 99);
        if (r < 6)
            c.pixel_count = 9'd0;
        else if (r < 90)
            c.pixel_count = 9'($urandom_range(1, 3));
        else if (r < 98)
            c.pixel_count = 9'($urandom_range(4, 10));
        else
            c.pixel_count = 9'($urandom_range(256, 511));
        c.color_order = $urandom_range(0, 1) ? RGB_ORDERS[$urandom_range(0, 5)]
                                             : 9'($urandom_range(0, 511));
        r = $urandom_range(0, 99);
        c.brightness = (r < 15) ? 8'd0 : (r < 30) ? 8'd255 : 8'($urandom);
        c.zero_high_ticks = ($urandom_range(0, 99) < 80) ? 12'($urandom_range(0, 6))
                                                         : 12'($urandom_range(0, 4095));
        c.one_high_ticks  = ($urandom_range(0, 99) < 80) ? 12'($urandom_range(0, 6))
                                                         : 12'($urandom_range(0, 4095));
        if (c.pixel_count > 10)
            c.bit_period_ticks = 12'($urandom_range(0, 2));
        else if ($urandom_range(0, 99) < 85)
            c.bit_period_ticks = 12'($urandom_range(0, 6));
        else
            c.bit_period_ticks = 12'($urandom_range(7, 40));
        c.reset_gap_ticks = 20'($urandom_range(0, 30));
        settle();
        apply_setting(c);
        n = (c.pixel_count > MAX_PIX) ? MAX_PIX : int'(c.pixel_count);

        shows = $urandom_range(1, 3);
        for (k = 0; k < shows; k++) begin
            for (i = $urandom_range(0, 5); i > 0; i--) begin
                it = rand_item();
                r  = $urandom_range(0, 99);
                if (r < 60) begin
                    it.cmd = CMD_SET;
                    if (n > 0 && $urandom_range(0, 4) != 0)
                        it.pixel_index = 8'($urandom_range(0, n - 1));
                end else if (r < 75) begin
                    it.cmd = CMD_FILL;
                end
                push_item(it);
            end
            if ($urandom_range(0, 4) == 0)
                push_cmd(CMD_SHOW, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            wait_show_ready(10);
            push_cmd(CMD_SHOW, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            run_out_frame(15);
        end
    endtask

    initial begin
        cfg_t c;
        int   start_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: the gap has not elapsed, only pixel 0 exists
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        push_cmd(CMD_SET,  8'h00, 8'hff, 8'h00, 8'h80);
        push_cmd(CMD_SET,  8'h01, 8'h12, 8'h34, 8'h56);
        push_cmd(CMD_TICK, 8'hff, 8'hff, 8'hff, 8'hff);
        settle();

        c = '{pixel_count: 9'd4, color_order: 9'd80, brightness: 8'd255,
              zero_high_ticks: 12'd1, one_high_ticks: 12'd2, bit_period_ticks: 12'd2,
              reset_gap_ticks: 20'd0};
        apply_setting(c);
        push_cmd(CMD_FILL, 8'h00, 8'h55, 8'haa, 8'h0f);
        push_cmd(CMD_SET,  8'h00, 8'hff, 8'hff, 8'hff);
        push_cmd(CMD_SET,  8'h03, 8'h00, 8'h00, 8'h00);
        push_cmd(CMD_SET,  8'hff, 8'h01, 8'h02, 8'h03);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        // writes and a second show are refused while the frame runs
        push_cmd(CMD_SET,  8'h01, 8'hff, 8'hff, 8'hff);
        push_cmd(CMD_FILL, 8'h00, 8'hff, 8'hff, 8'hff);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out_frame(0);
        settle();

        // offsets past the pixel end, one-tick slots, zero and full high times
        c = '{pixel_count: 9'd2, color_order: 9'o765, brightness: 8'd128,
              zero_high_ticks: 12'd0, one_high_ticks: 12'd4095, bit_period_ticks: 12'd1,
              reset_gap_ticks: 20'd3};
        apply_setting(c);
        push_cmd(CMD_SET, 8'h00, 8'h11, 8'h22, 8'h33);
        push_cmd(CMD_SET, 8'h01, 8'h44, 8'h55, 8'h66);
        settle();
        write_reg(REG_COLOR_ORDER, CFG_DATA_W'(9'o012));
        push_cmd(CMD_SET, 8'h01, 8'hc3, 8'h7e, 8'h81);
        settle();
        write_reg(REG_COLOR_ORDER, CFG_DATA_W'(9'o333));
        push_cmd(CMD_FILL, 8'h00, 8'hf0, 8'h0f, 8'hff);
        // show exactly at the gap is refused, the show right after it goes
        while (sb.frame_on || sb.idle_cnt < sb.reset_gap)
            filler(0);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (5) filler(0);
        // timing and brightness changed in the middle of the frame
        settle();
        write_reg(REG_BRIGHTNESS, CFG_DATA_W'(8'd255));
        write_reg(REG_BIT_PERIOD, CFG_DATA_W'(12'd0));
        write_reg(REG_ZERO_HIGH,  CFG_DATA_W'(12'd3));
        write_reg(REG_ONE_HIGH,   CFG_DATA_W'(12'd0));
        run_out_frame(20);
        settle();

        // empty strip: writes do nothing, a show sends nothing
        write_reg(REG_PIXEL_COUNT, CFG_DATA_W'(9'd0));
        write_reg(REG_RESET_GAP,   CFG_DATA_W'(20'd0));
        push_cmd(CMD_SET,  8'h00, 8'haa, 8'hbb, 8'hcc);
        push_cmd(CMD_FILL, 8'h00, 8'haa, 8'hbb, 8'hcc);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        settle();

        // pixel count above the store saturates: fill walks the whole store
        c = '{pixel_count: 9'd511, color_order: 9'o210, brightness: 8'd255,
              zero_high_ticks: 12'd1, one_high_ticks: 12'd2, bit_period_ticks: 12'd2,
              reset_gap_ticks: 20'd0};
        apply_setting(c);
        push_cmd(CMD_FILL, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom));
        push_cmd(CMD_SET,  8'hff, 8'hff, 8'hff, 8'hff);
        push_cmd(CMD_SET,  8'h00, 8'h00, 8'h00, 8'h00);
        settle();

        // high time longer than the bit slot
        c = '{pixel_count: 9'd1, color_order: 9'o012, brightness: 8'd255,
              zero_high_ticks: 12'd4095, one_high_ticks: 12'd0, bit_period_ticks: 12'd16,
              reset_gap_ticks: 20'd20};
        apply_setting(c);
        push_cmd(CMD_SET, 8'h00, 8'ha5, 8'h3c, 8'hff);
        wait_show_ready(0);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out_frame(2);
        settle();

        // largest gap: shows keep being refused
        c = '{pixel_count: 9'd1, color_order: 9'o777, brightness: 8'd0,
              zero_high_ticks: 12'd5, one_high_ticks: 12'd9, bit_period_ticks: 12'd12,
              reset_gap_ticks: 20'hfffff};
        apply_setting(c);
        push_cmd(CMD_SET,  8'h00, 8'h81, 8'h42, 8'h24);
        push_cmd(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        filler(0);
        push_cmd(CMD_SHOW, 8'hff, 8'hff, 8'hff, 8'hff);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
            random_phase();
        settle();

        $display("ran %0d transactions over %0d settings: %0d frames, %0d commands refused",
                 items_sent, phases, sb.frames, sb.rejects);
        $display("%0d results checked, %0d mismatches, %0d results missing",
                 sb.checked, sb.errors, sb.line_expected.size());
        if (sb.errors == 0 && sb.line_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
